>>> sv/afs_pkg.sv
// ----------------------------------------------------------------------------
// afs_pkg
// Shared constants, angle table and stage tags for the arrival steering block.
// ----------------------------------------------------------------------------
package afs_pkg;

  localparam int MAG_W   = 16;
  localparam int HEAD_W  = 16;
  localparam int ANGLE_W = 32;
  localparam int CFG_W   = 24;
  localparam int RAD_W   = 24;
  localparam int DEN_W   = 32;
  localparam int NUM_W   = 48;
  localparam int FORCE_W = 17;

  // 1/K of the CORDIC gain, Q0.24
  localparam logic [23:0]        INV_GAIN   = 24'd10188014;
  localparam logic signed [24:0] INV_GAIN_S = 25'sd10188014;

  typedef logic [1:0] cfg_index_t;
  localparam cfg_index_t REG_MAX_SPEED = 2'd0;
  localparam cfg_index_t REG_MIN_SPEED = 2'd1;
  localparam cfg_index_t REG_RADIUS    = 2'd2;

  // tag that rides along the magnitude divider
  typedef struct packed {
    logic              valid;
    logic              near;
    logic              zero;
    logic [HEAD_W-1:0] heading;
  } div_tag_t;

  // tag that rides along the rotation CORDIC
  typedef struct packed {
    logic              valid;
    logic              near;
    logic [MAG_W-1:0]  mag;
    logic [HEAD_W-1:0] heading;
  } rot_tag_t;

  // arctan(2^-s) in units of 2^-32 turn
  function automatic logic [ANGLE_W-1:0] atan_entry(input int unsigned s);
    logic [ANGLE_W-1:0] v;
    unique case (s)
      0:  v = 32'h20000000;
      1:  v = 32'h12E4051E;
      2:  v = 32'h09FB385B;
      3:  v = 32'h051111D4;
      4:  v = 32'h028B0D43;
      5:  v = 32'h0145D7E1;
      6:  v = 32'h00A2F61E;
      7:  v = 32'h00517C55;
      8:  v = 32'h0028BE53;
      9:  v = 32'h00145F2F;
      10: v = 32'h000A2F98;
      11: v = 32'h000517CC;
      12: v = 32'h00028BE6;
      13: v = 32'h000145F3;
      14: v = 32'h0000A2FA;
      15: v = 32'h0000517D;
      16: v = 32'h000028BE;
      17: v = 32'h0000145F;
      18: v = 32'h00000A30;
      19: v = 32'h00000518;
      20: v = 32'h0000028C;
      21: v = 32'h00000146;
      22: v = 32'h000000A3;
      23: v = 32'h00000051;
      24: v = 32'h00000029;
      25: v = 32'h00000014;
      26: v = 32'h0000000A;
      27: v = 32'h00000005;
      28: v = 32'h00000003;
      29: v = 32'h00000001;
      30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

>>> sv/afs_vector.sv
// ----------------------------------------------------------------------------
// afs_vector
// Pipelined vectoring CORDIC: bearing and raw (gained) length of a vector.
// ----------------------------------------------------------------------------
module afs_vector import afs_pkg::*; #(
  parameter int W      = 35,
  parameter int STAGES = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic signed [W-1:0] x_in,
  input  logic signed [W-1:0] y_in,
  output logic                out_valid,
  output logic signed [W-1:0] len_out,
  output logic [ANGLE_W-1:0]  ang_out
);

  logic signed [W-1:0]  xs [0:STAGES];
  logic signed [W-1:0]  ys [0:STAGES];
  logic [ANGLE_W-1:0]   zs [0:STAGES];
  logic                 vs [0:STAGES];
  logic                 zr [0:STAGES];

  // pre-rotate the left half plane by a quarter turn
  always_ff @(posedge clk) begin
    if (rst) begin
      vs[0] <= 1'b0;
    end else begin
      vs[0] <= in_valid;
    end
    zr[0] <= (x_in == '0) && (y_in == '0);
    if (x_in < 0) begin
      if (y_in >= 0) begin
        xs[0] <= y_in;
        ys[0] <= -x_in;
        zs[0] <= 32'h40000000;
      end else begin
        xs[0] <= -y_in;
        ys[0] <= x_in;
        zs[0] <= 32'hC0000000;
      end
    end else begin
      xs[0] <= x_in;
      ys[0] <= y_in;
      zs[0] <= '0;
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (rst) begin
        vs[i+1] <= 1'b0;
      end else begin
        vs[i+1] <= vs[i];
      end
      zr[i+1] <= zr[i];
      if (ys[i] >= 0) begin
        xs[i+1] <= xs[i] + (ys[i] >>> i);
        ys[i+1] <= ys[i] - (xs[i] >>> i);
        zs[i+1] <= zs[i] + atan_entry(i);
      end else begin
        xs[i+1] <= xs[i] - (ys[i] >>> i);
        ys[i+1] <= ys[i] + (xs[i] >>> i);
        zs[i+1] <= zs[i] - atan_entry(i);
      end
    end
  end

  // a zero vector has no bearing: report zero
  assign out_valid = vs[STAGES];
  assign len_out   = zr[STAGES] ? '0 : xs[STAGES];
  assign ang_out   = zr[STAGES] ? '0 : zs[STAGES];

endmodule

>>> sv/afs_divide.sv
// ----------------------------------------------------------------------------
// afs_divide
// Pipelined restoring divider, one quotient bit per stage, for the slowed
// magnitude max_speed * d / radius.
// ----------------------------------------------------------------------------
module afs_divide import afs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  div_tag_t          in_tag,
  input  logic [NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]  den,
  output div_tag_t          out_tag,
  output logic [MAG_W-1:0]  quot
);

  logic [DEN_W-1:0] rem  [0:MAG_W];
  logic [MAG_W-1:0] low  [0:MAG_W];
  logic [MAG_W-1:0] qb   [0:MAG_W];
  logic [DEN_W-1:0] dv   [0:MAG_W];
  div_tag_t         tg   [0:MAG_W];

  // quotient fits in MAG_W bits, so the top of the numerator is already a remainder
  assign rem[0] = num[NUM_W-1:MAG_W];
  assign low[0] = num[MAG_W-1:0];
  assign qb[0]  = '0;
  assign dv[0]  = den;
  assign tg[0]  = in_tag;

  for (genvar k = 0; k < MAG_W; k++) begin : g_step
    logic [DEN_W:0] trial;
    logic           ge;
    assign trial = {rem[k], low[k][MAG_W-1]};
    assign ge    = trial >= {1'b0, dv[k]};
    always_ff @(posedge clk) begin
      if (rst) begin
        tg[k+1].valid <= 1'b0;
      end else begin
        tg[k+1] <= tg[k];
      end
      rem[k+1] <= ge ? DEN_W'(trial - {1'b0, dv[k]}) : trial[DEN_W-1:0];
      low[k+1] <= {low[k][MAG_W-2:0], 1'b0};
      qb[k+1]  <= {qb[k][MAG_W-2:0], ge};
      dv[k+1]  <= dv[k];
    end
  end

  assign out_tag = tg[MAG_W];
  assign quot    = qb[MAG_W];

endmodule

>>> sv/afs_rotate.sv
// ----------------------------------------------------------------------------
// afs_rotate
// Pipelined rotation CORDIC: turns (magnitude, 0) by the heading error, then
// removes the gain, rounds and saturates to 17 bits.
// ----------------------------------------------------------------------------
module afs_rotate import afs_pkg::*; #(
  parameter int STAGES = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  rot_tag_t                   in_tag,
  output rot_tag_t                   out_tag,
  output logic signed [FORCE_W-1:0]  fx,
  output logic signed [FORCE_W-1:0]  fy
);

  localparam int XW = MAG_W + 11;
  localparam int ZW = ANGLE_W + 2;
  localparam int PW = XW + 25;
  localparam int RW = PW - 32;

  logic signed [XW-1:0] xs [0:STAGES];
  logic signed [XW-1:0] ys [0:STAGES];
  logic signed [ZW-1:0] zs [0:STAGES];
  rot_tag_t             tg [0:STAGES];

  logic signed [ZW-1:0] z_in;
  logic signed [XW-1:0] x_in;

  assign z_in = {{2{in_tag.heading[HEAD_W-1]}}, in_tag.heading, 16'h0000};
  assign x_in = $signed({3'b000, in_tag.mag, 8'h00});

  // fold headings beyond a quarter turn: negate and turn by a half turn
  always_ff @(posedge clk) begin
    if (rst) begin
      tg[0].valid <= 1'b0;
    end else begin
      tg[0] <= in_tag;
    end
    ys[0] <= '0;
    if (z_in > $signed(34'sh040000000)) begin
      xs[0] <= -x_in;
      zs[0] <= z_in - $signed(34'sh080000000);
    end else if (z_in < -$signed(34'sh040000000)) begin
      xs[0] <= -x_in;
      zs[0] <= z_in + $signed(34'sh080000000);
    end else begin
      xs[0] <= x_in;
      zs[0] <= z_in;
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    logic signed [ZW-1:0] step;
    assign step = $signed({2'b00, atan_entry(i)});
    always_ff @(posedge clk) begin
      if (rst) begin
        tg[i+1].valid <= 1'b0;
      end else begin
        tg[i+1] <= tg[i];
      end
      if (zs[i] >= 0) begin
        xs[i+1] <= xs[i] - (ys[i] >>> i);
        ys[i+1] <= ys[i] + (xs[i] >>> i);
        zs[i+1] <= zs[i] - step;
      end else begin
        xs[i+1] <= xs[i] + (ys[i] >>> i);
        ys[i+1] <= ys[i] - (xs[i] >>> i);
        zs[i+1] <= zs[i] + step;
      end
    end
  end

  // gain removal product
  logic signed [PW-1:0] px, py;
  rot_tag_t             tg_p;
  always_ff @(posedge clk) begin
    if (rst) begin
      tg_p.valid <= 1'b0;
    end else begin
      tg_p <= tg[STAGES];
    end
    px <= PW'(xs[STAGES] * INV_GAIN_S);
    py <= PW'(ys[STAGES] * INV_GAIN_S);
  end

  // round halves up, then clamp
  function automatic logic signed [FORCE_W-1:0] round_sat(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] s;
    logic signed [RW-1:0] r;
    s = p + $signed(PW'(64'h80000000));
    r = s[PW-1:32];
    if (r > $signed(RW'(65535))) begin
      return 17'sh0FFFF;
    end else if (r < -$signed(RW'(65536))) begin
      return 17'sh10000;
    end
    return r[FORCE_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      out_tag.valid <= 1'b0;
    end else begin
      out_tag <= tg_p;
    end
    fx <= round_sat(px);
    fy <= round_sat(py);
  end

endmodule

>>> sv/arrival_steering_force.sv
// ----------------------------------------------------------------------------
// arrival_steering_force
// Arrival steering: distance and bearing to the goal, slowed force magnitude
// inside the slowing radius, heading error against the velocity and the force
// vector built from them. Fully pipelined, one request per clock while busy is low.
// ----------------------------------------------------------------------------
//
//  channel   handshake                 payload
//  --------  ------------------------  -------------------------------------
//  request   start, busy               robot_x/y, velocity_x/y, goal_x/y
//  result    done (one-cycle strobe)   force_magnitude, heading_error,
//                                      force_x, force_y, inside_radius
//  config    cfg_valid, cfg_ready      cfg_index, cfg_data
//
//  The path from the accepting edge to done runs through two CORDIC chains of
//  CORDIC_STAGES steps (16 by default) and the 16-step magnitude divider.
//  A new request is taken every cycle while busy is low.
//  Reset is synchronous and clears the in-flight valid bits; busy is high
//  for the cycle after reset. The result side has no backpressure, so the
//  pipeline never stalls. cfg_ready is always high.
//
module arrival_steering_force import afs_pkg::*; #(
  parameter int CORDIC_STAGES = 16,
  parameter int COORD_WIDTH   = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] robot_x,
  input  logic signed [COORD_WIDTH-1:0] robot_y,
  input  logic signed [15:0]            velocity_x,
  input  logic signed [15:0]            velocity_y,
  input  logic signed [COORD_WIDTH-1:0] goal_x,
  input  logic signed [COORD_WIDTH-1:0] goal_y,
  output logic                          done,
  output logic [MAG_W-1:0]              force_magnitude,
  output logic signed [HEAD_W-1:0]      heading_error,
  output logic signed [FORCE_W-1:0]     force_x,
  output logic signed [FORCE_W-1:0]     force_y,
  output logic                          inside_radius,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  cfg_index_t                    cfg_index,
  input  logic [CFG_W-1:0]              cfg_data
);

  // offset width: difference, prescale by 256, CORDIC growth and pre-rotation
  localparam int DW   = COORD_WIDTH + 1;
  localparam int VW   = COORD_WIDTH + 11;
  localparam int VELW = 27;
  localparam int CMPW = (VW > DEN_W) ? VW : DEN_W;
  localparam int LAT  = 25 + 2 * CORDIC_STAGES;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [MAG_W-1:0] max_speed;
  logic [MAG_W-1:0] crawl_speed;
  logic [RAD_W-1:0] brake_radius;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_speed    <= 16'd256;
      crawl_speed  <= 16'd0;
      brake_radius <= 24'd256;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MAX_SPEED: max_speed    <= cfg_data[MAG_W-1:0];
        REG_MIN_SPEED: crawl_speed  <= cfg_data[MAG_W-1:0];
        REG_RADIUS:    brake_radius <= cfg_data;
        default: ;  // drop writes to unmapped indexes
      endcase
    end
  end

  // busy only while coming out of reset
  always_ff @(posedge clk) begin
    busy <= rst;
  end

  // --------------------------------------------------------------------------
  // Input stage: form the goal offset, prescale both vectors by 256
  // --------------------------------------------------------------------------
  logic                  in_valid;
  logic signed [VW-1:0]  off_x, off_y;
  logic signed [VELW-1:0] vel_x, vel_y;
  logic signed [DW-1:0]  dx, dy;

  assign dx = DW'(goal_x) - DW'(robot_x);
  assign dy = DW'(goal_y) - DW'(robot_y);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start && !busy;
    end
    off_x <= VW'($signed({dx, 8'h00}));
    off_y <= VW'($signed({dy, 8'h00}));
    vel_x <= VELW'($signed({velocity_x, 8'h00}));
    vel_y <= VELW'($signed({velocity_y, 8'h00}));
  end

  // --------------------------------------------------------------------------
  // Bearing and length of the offset, angle of the velocity
  // --------------------------------------------------------------------------
  logic                  vec_valid;
  logic signed [VW-1:0]  len;
  logic [ANGLE_W-1:0]    bearing;
  logic                  vel_valid;
  logic signed [VELW-1:0] vel_len;
  logic [ANGLE_W-1:0]    vel_ang;

  afs_vector #(.W(VW), .STAGES(CORDIC_STAGES)) u_offset (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .x_in     (off_x),
    .y_in     (off_y),
    .out_valid(vec_valid),
    .len_out  (len),
    .ang_out  (bearing)
  );

  // velocity length is not needed; only its angle
  afs_vector #(.W(VELW), .STAGES(CORDIC_STAGES)) u_velocity (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .x_in     (vel_x),
    .y_in     (vel_y),
    .out_valid(vel_valid),
    .len_out  (vel_len),
    .ang_out  (vel_ang)
  );

  // --------------------------------------------------------------------------
  // Gain stage: split the length so each product stays narrow; round the
  // heading error to 16 bits with wrap
  // --------------------------------------------------------------------------
  logic                  g_valid;
  logic [VW-2:0]         g_hi;
  logic [23:0]           g_lo;
  logic [HEAD_W-1:0]     g_head;
  logic [ANGLE_W-1:0]    ang_diff;
  logic [47:0]           lo_prod;

  assign ang_diff = bearing - vel_ang + 32'h00008000;
  assign lo_prod  = len[23:0] * INV_GAIN + 48'h800000;

  always_ff @(posedge clk) begin
    if (rst) begin
      g_valid <= 1'b0;
    end else begin
      g_valid <= vec_valid && vel_valid;
    end
    g_hi   <= (VW-1)'(len[VW-2:24] * INV_GAIN);
    g_lo   <= lo_prod[47:24];
    g_head <= ang_diff[31:16];
  end

  // --------------------------------------------------------------------------
  // Distance and the radius test
  // --------------------------------------------------------------------------
  logic                  d_valid;
  logic [CMPW-1:0]       d_dist;
  logic                  d_near;
  logic                  d_zero;
  logic [HEAD_W-1:0]     d_head;
  logic [CMPW-1:0]       dist_sum;
  logic [CMPW-1:0]       rad_ext;

  assign dist_sum = CMPW'(g_hi) + CMPW'(g_lo);
  assign rad_ext  = CMPW'({brake_radius, 8'h00});

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else begin
      d_valid <= g_valid;
    end
    d_dist <= dist_sum;
    d_near <= dist_sum <= rad_ext;
    d_zero <= dist_sum == '0;
    d_head <= g_head;
  end

  // --------------------------------------------------------------------------
  // Numerator of the slowed magnitude; inside the radius d fits in 32 bits
  // --------------------------------------------------------------------------
  div_tag_t          m_tag;
  logic [NUM_W-1:0]  m_num;
  logic [DEN_W-1:0]  m_den;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tag.valid <= 1'b0;
    end else begin
      m_tag <= '{valid: d_valid, near: d_near, zero: d_zero, heading: d_head};
    end
    m_num <= max_speed * d_dist[DEN_W-1:0];
    m_den <= {brake_radius, 8'h00};
  end

  div_tag_t          q_tag;
  logic [MAG_W-1:0]  q_val;

  afs_divide u_divide (
    .clk    (clk),
    .rst    (rst),
    .in_tag (m_tag),
    .num    (m_num),
    .den    (m_den),
    .out_tag(q_tag),
    .quot   (q_val)
  );

  // --------------------------------------------------------------------------
  // Magnitude select: full speed outside, clamped ratio inside, zero at goal
  // --------------------------------------------------------------------------
  rot_tag_t          s_tag;
  logic [MAG_W-1:0]  mag_next;

  always_comb begin
    priority if (!q_tag.near) begin
      mag_next = max_speed;
    end else if (q_tag.zero) begin
      mag_next = '0;
    end else if (q_val > crawl_speed) begin
      mag_next = q_val;
    end else begin
      mag_next = crawl_speed;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_tag.valid <= 1'b0;
    end else begin
      s_tag <= '{valid: q_tag.valid, near: q_tag.near, mag: mag_next,
                 heading: q_tag.heading};
    end
  end

  // --------------------------------------------------------------------------
  // Force vector; its output registers are the result registers
  // --------------------------------------------------------------------------
  rot_tag_t r_tag;

  afs_rotate #(.STAGES(CORDIC_STAGES)) u_rotate (
    .clk    (clk),
    .rst    (rst),
    .in_tag (s_tag),
    .out_tag(r_tag),
    .fx     (force_x),
    .fy     (force_y)
  );

  assign done            = r_tag.valid;
  assign force_magnitude = r_tag.mag;
  assign heading_error   = $signed(r_tag.heading);
  assign inside_radius   = r_tag.near;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LAT done)
    else $error("request did not complete at the fixed latency");

  a_outside_mag: assert property (@(posedge clk) disable iff (rst)
    (done && !inside_radius) |-> (force_magnitude == max_speed))
    else $error("magnitude outside the radius differs from max_speed");

  a_both_vectors: assert property (@(posedge clk) disable iff (rst)
    vec_valid == vel_valid)
    else $error("offset and velocity CORDIC out of step");

endmodule

>>> bench/afs_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// afs_checker
// Watches the request, result and config channels of the arrival steering
// block, predicts each result from its own model and compares field by field.
// ----------------------------------------------------------------------------
module afs_checker import afs_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic                     busy,
  input  logic signed [23:0]       robot_x,
  input  logic signed [23:0]       robot_y,
  input  logic signed [15:0]       velocity_x,
  input  logic signed [15:0]       velocity_y,
  input  logic signed [23:0]       goal_x,
  input  logic signed [23:0]       goal_y,
  input  logic                     done,
  input  logic [MAG_W-1:0]         force_magnitude,
  input  logic signed [HEAD_W-1:0] heading_error,
  input  logic signed [FORCE_W-1:0] force_x,
  input  logic signed [FORCE_W-1:0] force_y,
  input  logic                     inside_radius,
  input  logic                     cfg_valid,
  input  logic                     cfg_ready,
  input  cfg_index_t               cfg_index,
  input  logic [CFG_W-1:0]         cfg_data,
  output int                       fail_count,
  output int                       pending
);

  localparam int STAGES = 16;
  localparam longint GAIN = 10188014;

  typedef struct packed {
    logic [15:0]        mag;
    logic [15:0]        head;
    logic [16:0]        fx;
    logic [16:0]        fy;
    logic               near;
  } steer_t;

  steer_t      steer_q[$];
  logic [15:0] speed_max, speed_min;
  logic [23:0] radius;

  // floor shift right
  function automatic longint fshr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint atan_turn(int s);
    return longint'(atan_entry(s));
  endfunction

  // vectoring CORDIC: angle in 2^-32 turn, raw length with gain
  function automatic logic [31:0] bearing(longint x, longint y, output longint len);
    longint z, t, xs, ys;
    z = 0;
    if (x == 0 && y == 0) begin
      len = 0;
      return 32'd0;
    end
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = 64'h40000000;
      end else begin
        x = -y; y = t; z = -64'h40000000;
      end
    end
    for (int i = 0; i < STAGES; i++) begin
      xs = fshr(x, i);
      ys = fshr(y, i);
      if (y >= 0) begin
        x += ys; y -= xs; z += atan_turn(i);
      end else begin
        x -= ys; y += xs; z -= atan_turn(i);
      end
    end
    len = x;
    return z[31:0];
  endfunction

  function automatic longint clamp17(longint v);
    if (v > 65535) return 65535;
    if (v < -65536) return -65536;
    return v;
  endfunction

  function automatic steer_t predict_steer(longint dx, longint dy, longint vx, longint vy);
    steer_t r;
    longint len, vlen, d, rad, q, a, x, y, z, xs, ys;
    logic [31:0] brg, vang, diff;
    logic [15:0] h;
    brg  = bearing(dx * 256, dy * 256, len);
    vang = bearing(vx * 256, vy * 256, vlen);
    d = (len >>> 24) * GAIN + (((len & 64'hFFFFFF) * GAIN + 64'h800000) >>> 24);
    rad = longint'(radius) * 256;
    r.near = (d <= rad);
    if (d > rad) r.mag = speed_max;
    else if (d == 0) r.mag = 16'd0;
    else begin
      q = (longint'(speed_max) * d) / rad;
      r.mag = (q > speed_min) ? q[15:0] : speed_min;
    end
    diff = brg - vang;
    h = 16'((diff + 32'h8000) >> 16);
    r.head = h;
    a = longint'($signed(h));
    z = a * 65536;
    x = longint'(r.mag) * 256;
    y = 0;
    if (z > 64'sh40000000 || z < -64'sh40000000) begin
      x = -x;
      z = (z > 0) ? z - 64'sh80000000 : z + 64'sh80000000;
    end
    for (int i = 0; i < STAGES; i++) begin
      xs = fshr(x, i);
      ys = fshr(y, i);
      if (z >= 0) begin
        x -= ys; y += xs; z -= atan_turn(i);
      end else begin
        x += ys; y -= xs; z += atan_turn(i);
      end
    end
    r.fx = 17'(clamp17((x * GAIN + 64'sh80000000) >>> 32));
    r.fy = 17'(clamp17((y * GAIN + 64'sh80000000) >>> 32));
    return r;
  endfunction

  assign pending = steer_q.size();

  always @(posedge clk) begin
    steer_t e;
    if (rst) begin
      speed_max <= 16'd256;
      speed_min <= 16'd0;
      radius    <= 24'd256;
      fail_count <= 0;
      steer_q.delete();
    end else begin
      if (done) begin
        if (steer_q.size() == 0) begin
          $error("result with nothing expected");
          fail_count <= fail_count + 1;
        end else begin
          e = steer_q.pop_front();
          if (force_magnitude !== e.mag || heading_error !== e.head || force_x !== e.fx ||
              force_y !== e.fy || inside_radius !== e.near) begin
            fail_count <= fail_count + 1;
            if (force_magnitude !== e.mag)
              $error("force_magnitude exp %0d got %0d", e.mag, force_magnitude);
            if (heading_error !== e.head)
              $error("heading_error exp %0d got %0d", $signed(e.head), heading_error);
            if (force_x !== e.fx)
              $error("force_x exp %0d got %0d", $signed(e.fx), force_x);
            if (force_y !== e.fy)
              $error("force_y exp %0d got %0d", $signed(e.fy), force_y);
            if (inside_radius !== e.near)
              $error("inside_radius exp %0d got %0d", e.near, inside_radius);
          end
        end
      end
      if (start && !busy)
        steer_q.push_back(predict_steer(longint'(goal_x) - longint'(robot_x),
            longint'(goal_y) - longint'(robot_y), longint'(velocity_x),
            longint'(velocity_y)));
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MAX_SPEED: speed_max <= cfg_data[15:0];
          REG_MIN_SPEED: speed_min <= cfg_data[15:0];
          REG_RADIUS:    radius    <= cfg_data;
          default: ;
        endcase
      end
    end
  end

endmodule

>>> bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the arrival steering block: directed corner cases,
// then random requests under several register settings with random gaps.
// ----------------------------------------------------------------------------
module tb;
  import afs_pkg::*;

  localparam int LATENCY = 57;
  localparam int CYCLE_LIMIT = 400000;
  localparam cfg_index_t REG_UNMAPPED = 2'd3;

  logic clk, rst, start, busy, done, inside_radius, cfg_valid, cfg_ready;
  logic signed [23:0] robot_x, robot_y, goal_x, goal_y;
  logic signed [15:0] velocity_x, velocity_y;
  logic [MAG_W-1:0] force_magnitude;
  logic signed [HEAD_W-1:0] heading_error;
  logic signed [FORCE_W-1:0] force_x, force_y;
  cfg_index_t cfg_index;
  logic [CFG_W-1:0] cfg_data;
  int fail_count, pending, cycles, sent;

  arrival_steering_force uut (.*);
  afs_checker chk (.*);

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // watchdog: a hung pipeline ends the run as a failure
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // write one register while the block is idle
  task automatic write_reg(cfg_index_t idx, logic [23:0] val);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // hold a request until the block takes it, then sometimes drop start for a random gap
  task automatic send_request(logic signed [23:0] rx, logic signed [23:0] ry,
                              logic signed [15:0] vx, logic signed [15:0] vy,
                              logic signed [23:0] gx, logic signed [23:0] gy);
    int gap;
    start <= 1'b1;
    robot_x <= rx; robot_y <= ry; velocity_x <= vx; velocity_y <= vy;
    goal_x <= gx; goal_y <= gy;
    do @(posedge clk); while (busy);
    sent++;
    gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : 0;
    if ($urandom_range(0, 40) == 0) gap = $urandom_range(10, 80);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // advance until the pipeline has drained
  task automatic drain;
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  // random offsets: one of three spans around the robot, or full range
  task automatic random_request;
    logic signed [23:0] rx, ry, span;
    rx = 24'($urandom); ry = 24'($urandom);
    case ($urandom_range(0, 3))
      0: span = 24'sd255;
      1: span = 24'sd4000;
      2: span = 24'sd200000;
      default: span = 24'sd8388607;
    endcase
    if (span == 24'sd8388607)
      send_request(rx, ry, 16'($urandom), 16'($urandom), 24'($urandom), 24'($urandom));
    else
      send_request(rx, ry, 16'($urandom), 16'($urandom),
                   rx + 24'($signed($urandom_range(0, 2 * span)) - span),
                   ry + 24'($signed($urandom_range(0, 2 * span)) - span));
  endtask

  initial begin
    logic [23:0] radii [4];
    rst = 1'b1; start = 1'b0; cfg_valid = 1'b0; cfg_index = REG_MAX_SPEED;
    cfg_data = '0; robot_x = '0; robot_y = '0; goal_x = '0; goal_y = '0;
    velocity_x = '0; velocity_y = '0; cycles = 0; sent = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: zero offset, zero velocity, extremes, heading of pi
    send_request('0, '0, '0, '0, '0, '0);
    send_request(24'sh7FFFFF, 24'sh7FFFFF, 16'sh7FFF, 16'sh7FFF, 24'sh800000, 24'sh800000);
    send_request(24'sh800000, 24'sh800000, 16'sh8000, 16'sh8000, 24'sh7FFFFF, 24'sh7FFFFF);
    send_request('0, '0, 16'sh0100, '0, -24'sd100, '0);
    send_request('0, '0, 16'sh0100, '0, 24'sd100, '0);
    send_request('0, '0, '0, 16'sh0100, '0, 24'sd256);
    send_request('0, '0, '0, 16'sh8000, 24'sd256, '0);
    send_request('0, '0, 16'sh0100, 16'sh0100, 24'sd128, -24'sd128);
    send_request(24'sd5, -24'sd5, 16'sh0001, 16'shFFFF, 24'sd6, -24'sd5);
    drain();

    // saturation, a high min speed, zero radius
    write_reg(REG_MAX_SPEED, 24'hFFFF);
    write_reg(REG_MIN_SPEED, 24'h8000);
    write_reg(REG_RADIUS, 24'd0);
    send_request('0, '0, '0, '0, '0, '0);
    send_request('0, '0, 16'sh0100, '0, 24'sd1, '0);
    send_request('0, '0, 16'sh0100, 16'sh0100, 24'sd3000, 24'sd3000);
    send_request('0, '0, 16'sh0100, '0, -24'sd3000, 24'sd10);
    drain();
    write_reg(REG_MAX_SPEED, 24'h0100);
    write_reg(REG_RADIUS, 24'hFFFFFF);
    send_request('0, '0, 16'sh0100, '0, 24'sd100, 24'sd100);
    send_request(24'sh800000, '0, '0, '0, 24'sh7FFFFF, '0);
    drain();
    // out-of-range index is ignored
    write_reg(REG_UNMAPPED, 24'h123456);

    radii = '{24'd1, 24'd256, 24'd5000, 24'hFFFFFF};
    for (int phase = 0; phase < 6; phase++) begin
      write_reg(REG_MAX_SPEED, (phase == 0) ? 24'h0 : 24'($urandom_range(0, 65535)));
      write_reg(REG_MIN_SPEED, (phase == 1) ? 24'hFFFF : 24'($urandom_range(0, 512)));
      write_reg(REG_RADIUS,
                radii[phase % 4] + ((phase > 3) ? 24'($urandom_range(0, 999)) : 24'd0));
      repeat (100) random_request();
      drain();
    end

    $display("Covered %0d requests: corner offsets, saturation and six register settings.",
             sent);
    if (fail_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

>>> sim.f
sv/afs_pkg.sv
sv/afs_vector.sv
sv/afs_divide.sv
sv/afs_rotate.sv
sv/arrival_steering_force.sv
bench/afs_checker.sv
bench/tb.sv
